[hw/rtl/mcq_pkg.sv]
// package for the per-class queue bank
// sizes, payload structs, result codes and controller types; no dependencies
`default_nettype none

package mcq_pkg;

  localparam int NUM_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int ID_WIDTH    = 16;

  localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ENTRY_W   = ID_WIDTH + 1;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [1:0] RES_ADDED  = 2'd0;
  localparam logic [1:0] RES_FULL   = 2'd1;
  localparam logic [1:0] RES_SERVED = 2'd2;
  localparam logic [1:0] RES_EMPTY  = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [3:0]  queue_index;
    logic [15:0] item_id;
    logic        urgent;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] served_id;
    logic        served_urgent;
    logic [3:0]  count_after;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic holding;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/mcq_ctrl.sv]
// controller for the per-class queue bank: sequences load, execute and reply
// depends on mcq_pkg
`default_nettype none

module mcq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  input  wire mcq_pkg::status_t status,
  output mcq_pkg::cmd_t        cmd
);

  mcq_pkg::state_t state;
  mcq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      mcq_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = mcq_pkg::ST_EXEC;
        end
      end
      mcq_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = mcq_pkg::ST_DONE;
      end
      mcq_pkg::ST_DONE: begin
        rsp_valid = status.holding;
        if (!rsp_stall) begin
          state_next = mcq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/mcq_datapath.sv]
// datapath for the per-class queue bank: counts, head pointers, entry store
// each class is a ring in the entry store; depends on mcq_pkg
`default_nettype none

module mcq_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mcq_pkg::cmd_t cmd,
  input  wire mcq_pkg::req_t req,
  output mcq_pkg::rsp_t      rsp,
  output mcq_pkg::status_t   status
);

  localparam logic [mcq_pkg::CNT_W-1:0] DEPTH_C = mcq_pkg::CNT_W'(mcq_pkg::QUEUE_DEPTH);
  localparam logic [mcq_pkg::CNT_W:0] DEPTH_S = (mcq_pkg::CNT_W + 1)'(mcq_pkg::QUEUE_DEPTH);
  localparam logic [mcq_pkg::PTR_W-1:0] LAST_P =
    mcq_pkg::PTR_W'(mcq_pkg::QUEUE_DEPTH - 1);
  localparam logic [mcq_pkg::ADDR_W-1:0] DEPTH_A =
    mcq_pkg::ADDR_W'(mcq_pkg::QUEUE_DEPTH);
  localparam logic [mcq_pkg::QIDX_W+3:0] NUMQ_W =
    (mcq_pkg::QIDX_W + 4)'(mcq_pkg::NUM_QUEUES);

  mcq_pkg::req_t req_q;

  logic [mcq_pkg::CNT_W-1:0]   counts [mcq_pkg::NUM_QUEUES];
  logic [mcq_pkg::PTR_W-1:0]   heads  [mcq_pkg::NUM_QUEUES];
  logic [mcq_pkg::ENTRY_W-1:0] store  [mcq_pkg::MEM_DEPTH];
  logic [mcq_pkg::ENTRY_W-1:0] rd_data;

  logic [1:0]                res_code;
  logic [mcq_pkg::CNT_W-1:0] res_cnt;
  logic                      holding;

  logic [mcq_pkg::QIDX_W+3:0]   q_wide;
  logic [mcq_pkg::QIDX_W-1:0]   qi;
  logic                         q_ok;
  logic [mcq_pkg::CNT_W-1:0]    cnt;
  logic [mcq_pkg::PTR_W-1:0]    head;
  logic [mcq_pkg::CNT_W:0]      tail_sum;
  logic [mcq_pkg::CNT_W:0]      tail_wrap;
  logic [mcq_pkg::PTR_W-1:0]    slot;
  logic [mcq_pkg::ADDR_W-1:0]   addr;
  logic [mcq_pkg::ID_WIDTH+15:0] id_wide;
  logic [mcq_pkg::ENTRY_W-1:0]  wr_data;
  logic                         wr_en;
  logic                         rd_en;
  logic                         upd_en;
  logic [mcq_pkg::CNT_W-1:0]    cnt_new;
  logic [mcq_pkg::PTR_W-1:0]    head_new;
  logic [1:0]                   code_new;
  logic [mcq_pkg::CNT_W-1:0]    cnt_out;
  logic [mcq_pkg::CNT_W+3:0]    cnt_wide;
  logic [mcq_pkg::ID_WIDTH+15:0] sid_wide;

  always_comb begin
    q_wide    = {{mcq_pkg::QIDX_W{1'b0}}, req_q.queue_index};
    qi        = q_wide[mcq_pkg::QIDX_W-1:0];
    q_ok      = q_wide < NUMQ_W;
    cnt       = counts[qi];
    head      = heads[qi];
    tail_sum  = {1'b0, cnt} + (mcq_pkg::CNT_W + 1)'(head);
    tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    id_wide   = {{mcq_pkg::ID_WIDTH{1'b0}}, req_q.item_id};
    wr_data   = {req_q.urgent, id_wide[mcq_pkg::ID_WIDTH-1:0]};
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    upd_en    = 1'b0;
    cnt_new   = cnt;
    head_new  = head;
    slot      = head;
    code_new  = (req_q.mode == mcq_pkg::MODE_TAKE) ? mcq_pkg::RES_EMPTY
                                                  : mcq_pkg::RES_FULL;
    cnt_out   = '0;
    if (q_ok) begin
      cnt_out = cnt;
      if (req_q.mode == mcq_pkg::MODE_ADD) begin
        if (cnt == DEPTH_C) begin
          code_new = mcq_pkg::RES_FULL;
        end else begin
          code_new = mcq_pkg::RES_ADDED;
          wr_en    = cmd.exec;
          upd_en   = cmd.exec;
          cnt_new  = cnt + 1'b1;
          if (req_q.urgent) begin
            slot     = (head == '0) ? LAST_P : head - 1'b1;
            head_new = slot;
          end else begin
            slot = tail_wrap[mcq_pkg::PTR_W-1:0];
          end
          cnt_out = cnt_new;
        end
      end else begin
        if (cnt == '0) begin
          code_new = mcq_pkg::RES_EMPTY;
        end else begin
          code_new = mcq_pkg::RES_SERVED;
          rd_en    = cmd.exec;
          upd_en   = cmd.exec;
          cnt_new  = cnt - 1'b1;
          head_new = (head == LAST_P) ? '0 : head + 1'b1;
          cnt_out  = cnt_new;
        end
      end
    end
    addr = (mcq_pkg::ADDR_W'(qi) * DEPTH_A) + mcq_pkg::ADDR_W'(slot);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      res_code <= code_new;
      res_cnt  <= cnt_out;
    end
    if (wr_en) begin
      store[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      for (int i = 0; i < mcq_pkg::NUM_QUEUES; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
      end
    end else begin
      if (cmd.exec) begin
        holding <= 1'b1;
      end else if (cmd.load) begin
        holding <= 1'b0;
      end
      if (upd_en) begin
        counts[qi] <= cnt_new;
        heads[qi]  <= head_new;
      end
    end
  end

  always_comb begin
    cnt_wide = {4'b0, res_cnt};
    sid_wide = {16'b0, rd_data[mcq_pkg::ID_WIDTH-1:0]};
    rsp.result_code = res_code;
    rsp.count_after = cnt_wide[3:0];
    if (res_code == mcq_pkg::RES_SERVED) begin
      rsp.served_id     = sid_wide[15:0];
      rsp.served_urgent = rd_data[mcq_pkg::ENTRY_W-1];
    end else begin
      rsp.served_id     = '0;
      rsp.served_urgent = 1'b0;
    end
    status.holding = holding;
  end

endmodule

`default_nettype wire

[hw/rtl/multi_class_two_priority_queue.sv]
// timing: a request is accepted, executed the next cycle, and its beat is
// offered the cycle after; a new request waits for the reply step of the
// controller (idle, execute, reply) to end; the store read is registered
// reset: counts and head pointers clear in the reset cycle, no clearing pass;
// entry storage is left as it is. depends on mcq_pkg, mcq_ctrl, mcq_datapath
`default_nettype none

module multi_class_two_priority_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire mcq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output mcq_pkg::rsp_t      rsp
);

  mcq_pkg::cmd_t    cmd;
  mcq_pkg::status_t status;

  mcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mcq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .rsp    (rsp),
    .status (status)
  );

endmodule

`default_nettype wire
